// ===== sv/knob_mp_pkg.sv =====
// ----------------------------------------------------------------------------
// knob_mp_pkg
// Shared types, constants and helpers for the knob panel message parser.
// ----------------------------------------------------------------------------
package knob_mp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TICK_W  = 10;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned SW_W    = 2;
    localparam int unsigned UT_W    = 2;
    localparam int unsigned TDATA_W = 24;

    localparam logic [CHAN_W-1:0] CHAN_LIMIT     = 4'd9;
    localparam logic [SW_W-1:0]   SW_FB          = 2'd1;
    localparam logic [SW_W-1:0]   SW_FA          = 2'd2;
    localparam logic [UT_W-1:0]   UT_ZERO        = 2'd0;
    localparam logic [UT_W-1:0]   UT_ALL         = 2'd3;
    localparam logic [TICK_W-1:0] CCW_LIMIT      = 10'h39F;
    localparam logic [TICK_W-1:0] CCW_MAX_MAG    = 10'h060;
    localparam logic [TICK_W-1:0] MAX_STEP_RESET = 10'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIGH,
        ST_LOW
    } t_state;

    // fields of the last accepted high byte
    typedef struct packed {
        logic [CHAN_W-1:0] knob_id;
        logic [SW_W-1:0]   switch_code;
        logic [UT_W-1:0]   upper_ticks;
    } t_hold;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [SW_W-1:0]   switch_pos;
        logic              counter_clockwise;
        logic [TICK_W-1:0] tick_count;
    } t_result;

    // decode outcome for one byte
    typedef struct packed {
        t_state  state_n;
        logic    save_stamp;
        logic    load_hold;
        t_hold   hold_n;
        logic    report;
        t_result res;
    } t_step;

    function automatic logic high_valid(input logic [BYTE_W-1:0] b);
        logic [CHAN_W-1:0] ch;
        logic [SW_W-1:0]   sw;
        logic [UT_W-1:0]   tk;
        ch = b[7:4];
        sw = b[3:2];
        tk = b[1:0];
        return (ch < CHAN_LIMIT) && ((sw == SW_FB) || (sw == SW_FA))
            && ((tk == UT_ZERO) || (tk == UT_ALL));
    endfunction

    function automatic t_hold split_high(input logic [BYTE_W-1:0] b);
        t_hold h;
        h.knob_id     = b[7:4];
        h.switch_code = b[3:2];
        h.upper_ticks = b[1:0];
        return h;
    endfunction

endpackage

// ===== sv/knob_mp_decode.sv =====
// ----------------------------------------------------------------------------
// knob_mp_decode
// Per-byte framing decision: next framer state, held fields and report.
// ----------------------------------------------------------------------------
module knob_mp_decode (
    input  knob_mp_pkg::t_state                      i_state,
    input  logic [knob_mp_pkg::BYTE_W-1:0]           i_byte,
    input  logic [knob_mp_pkg::BYTE_W-1:0]           i_saved_stamp,
    input  knob_mp_pkg::t_hold                       i_hold,
    input  logic [knob_mp_pkg::TICK_W-1:0]           i_max_step,
    output knob_mp_pkg::t_step                       o_step
);

    logic                            byte_high_ok;
    logic                            saved_high_ok;
    logic                            use_saved;
    knob_mp_pkg::t_hold              src_hold;
    logic [knob_mp_pkg::TICK_W-1:0]  ticks;
    logic                            ccw;
    logic [knob_mp_pkg::TICK_W-1:0]  mag;
    logic                            mag_ok;

    assign byte_high_ok  = knob_mp_pkg::high_valid(i_byte);
    assign saved_high_ok = knob_mp_pkg::high_valid(i_saved_stamp);
    // missing high byte: retry with the saved stamp byte as the high byte
    assign use_saved     = (i_state == knob_mp_pkg::ST_HIGH) && !byte_high_ok && saved_high_ok;
    assign src_hold      = use_saved ? knob_mp_pkg::split_high(i_saved_stamp) : i_hold;

    assign ticks  = {src_hold.upper_ticks, i_byte};
    assign ccw    = ticks > knob_mp_pkg::CCW_LIMIT;
    // 1024 - ticks, modulo 2^10
    assign mag    = ccw ? (~ticks + 10'd1) : ticks;
    assign mag_ok = mag <= i_max_step;

    always_comb begin
        o_step                       = '0;
        o_step.state_n               = i_state;
        o_step.hold_n                = knob_mp_pkg::split_high(i_byte);
        o_step.res.channel           = src_hold.knob_id;
        o_step.res.switch_pos        = src_hold.switch_code;
        o_step.res.counter_clockwise = ccw;
        o_step.res.tick_count        = mag;
        unique case (i_state)
            knob_mp_pkg::ST_IDLE: begin
                if (i_byte[0]) begin
                    o_step.state_n    = knob_mp_pkg::ST_HIGH;
                    o_step.save_stamp = 1'b1;
                end else if (byte_high_ok) begin
                    o_step.state_n   = knob_mp_pkg::ST_LOW;
                    o_step.load_hold = 1'b1;
                end
            end
            knob_mp_pkg::ST_HIGH: begin
                if (byte_high_ok) begin
                    o_step.state_n   = knob_mp_pkg::ST_LOW;
                    o_step.load_hold = 1'b1;
                end else if (saved_high_ok) begin
                    o_step.state_n   = knob_mp_pkg::ST_IDLE;
                    o_step.load_hold = 1'b1;
                    o_step.hold_n    = src_hold;
                    o_step.report    = mag_ok;
                end
            end
            knob_mp_pkg::ST_LOW: begin
                o_step.report = mag_ok;
                // rejected step: byte may start a new frame as a stamp (not saved)
                if (!mag_ok && i_byte[0]) begin
                    o_step.state_n = knob_mp_pkg::ST_HIGH;
                end else begin
                    o_step.state_n = knob_mp_pkg::ST_IDLE;
                end
            end
            default: begin
                o_step.state_n = knob_mp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/knob_encoder_message_parser_top.sv =====
// ----------------------------------------------------------------------------
// knob_encoder_message_parser_top
// Frames the knob panel byte stream into stamp/high/low messages and emits
// one rotation report per completed message within the step limit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received panel byte per beat (tdata[7:0]).
//   m_axis carries one report per beat; most bytes produce none.
//   The cfg channel writes max_step (10 bits); it is always ready and
//   should only be written while no bytes are in flight.
// Timing:
//   A byte is registered on input, decoded against the framer state and its
//   report lands in the output register. One byte per cycle is sustained
//   while no report waits on m_axis_tready; the framer state loop runs
//   through the decode logic alone.
// Reset:
//   Synchronous, active low. Framer returns to idle, saved stamp and held
//   fields clear, max_step returns to 64.
// Stall:
//   While a report waits on m_axis_tready, the input register still takes
//   a byte when it is empty, so one more byte is taken before s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
module knob_encoder_message_parser_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] channel, [5:4] switch_pos, [6] counter_clockwise, [16:7] tick_count
    output logic [knob_mp_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [knob_mp_pkg::TICK_W-1:0]      i_cfg_data
);

    logic                                r_in_valid;
    logic [knob_mp_pkg::BYTE_W-1:0]      r_in_byte;
    knob_mp_pkg::t_state                 r_state;
    knob_mp_pkg::t_state                 n_state;
    logic [knob_mp_pkg::BYTE_W-1:0]      r_saved_stamp;
    knob_mp_pkg::t_hold                  r_hold;
    logic [knob_mp_pkg::TICK_W-1:0]      r_max_step;
    logic                                r_out_valid;
    knob_mp_pkg::t_result                r_out;
    knob_mp_pkg::t_step                  step;
    logic                                advance;
    logic                                fire;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    knob_mp_decode u_decode (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_saved_stamp (r_saved_stamp),
        .i_hold        (r_hold),
        .i_max_step    (r_max_step),
        .o_step        (step)
    );

    always_comb begin
        n_state = r_state;
        if (fire) begin
            n_state = step.state_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_state       <= knob_mp_pkg::ST_IDLE;
            r_saved_stamp <= '0;
            r_hold        <= '0;
            r_max_step    <= knob_mp_pkg::MAX_STEP_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire && step.save_stamp) begin
                r_saved_stamp <= r_in_byte;
            end
            if (fire && step.load_hold) begin
                r_hold <= step.hold_n;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_step <= i_cfg_data;
            end
            if (advance) begin
                r_out_valid <= fire && step.report;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (fire && step.report) begin
            r_out <= step.res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.tick_count, r_out.counter_clockwise,
                            r_out.switch_pos, r_out.channel};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_report_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && step.report) |=> m_axis_tvalid)
        else $error("decoded report did not reach output register");

    a_ccw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |->
        (m_axis_tdata[16:7] != 10'd0 && m_axis_tdata[16:7] <= knob_mp_pkg::CCW_MAX_MAG))
        else $error("counter-clockwise magnitude out of range");

    a_out_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] < knob_mp_pkg::CHAN_LIMIT &&
        (m_axis_tdata[5:4] == knob_mp_pkg::SW_FB || m_axis_tdata[5:4] == knob_mp_pkg::SW_FA)))
        else $error("report carries fields of an invalid high byte");

    a_low_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == knob_mp_pkg::ST_LOW) |->
        (r_hold.upper_ticks == knob_mp_pkg::UT_ZERO || r_hold.upper_ticks == knob_mp_pkg::UT_ALL))
        else $error("waiting for low byte without a valid held high byte");

    a_stamp_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && step.save_stamp) |=> r_saved_stamp[0])
        else $error("saved stamp byte is not odd");

endmodule
